### hw/rtl/swdh_pkg.sv
// ----------------------------------------------------------------------------
// swdh_pkg
// Types, codes and helpers shared by the SWD host transfer engine
// ----------------------------------------------------------------------------
package swdh_pkg;

	localparam int unsigned MAX_ATTEMPTS = 8;
	localparam int unsigned ATT_W        = 3;
	localparam int unsigned CNT_W        = 8;
	localparam int unsigned WORD_W       = 32;
	localparam int unsigned ADDR_W       = 4;
	localparam int unsigned TDATA_IN_W   = 40;
	localparam int unsigned TDATA_OUT_W  = 40;

	localparam logic [2:0] ACK_OK    = 3'b001;
	localparam logic [2:0] ACK_WAIT  = 3'b010;
	localparam logic [2:0] ACK_FAULT = 3'b100;
	localparam logic [2:0] ACK_NONE  = 3'b111;

	localparam int unsigned REQ_RNW_BIT = 1;

	localparam logic [1:0] REG_TURN   = 2'd0;
	localparam logic [1:0] REG_DPHASE = 2'd1;
	localparam logic [1:0] REG_IDLE   = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HDR,
		PH_TURN_A,
		PH_ACK,
		PH_RD,
		PH_TURN_B,
		PH_WR,
		PH_IDLE_BITS
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_WAIT,
		ST_FAULT,
		ST_NO_ACK,
		ST_PARITY,
		ST_BAD_ACK
	} status_t;

	typedef struct packed {
		logic [2:0] turnaround_cycles;
		logic       data_phase_on_error;
		logic [7:0] idle_len;
	} cfg_t;

	typedef struct packed {
		logic              cmd;
		logic              line_in;
		logic [WORD_W-1:0] write_data;
		logic [3:0]        request;
	} item_t;

	// line_out sits in the lowest bit
	typedef struct packed {
		logic [WORD_W-1:0] read_data;
		status_t           status;
		logic              done_res;
		logic              busy_res;
		logic              clock_pulse;
		logic              line_drive;
		logic              line_out;
	} result_t;

	function automatic logic [2:0] turn_len(input logic [2:0] t);
		logic [2:0] r;
		r = t;
		if (t == 3'd0) begin
			r = 3'd1;
		end else if (t > 3'd4) begin
			r = 3'd4;
		end
		return r;
	endfunction

	function automatic logic [7:0] header_bits(input logic [3:0] r);
		logic p;
		p = ^r;
		return {1'b1, 1'b0, p, r, 1'b1};
	endfunction

	function automatic status_t error_status(input logic [2:0] ack);
		status_t s;
		priority if (ack == ACK_WAIT) begin
			s = ST_WAIT;
		end else if (ack == ACK_FAULT) begin
			s = ST_FAULT;
		end else if (ack == ACK_NONE) begin
			s = ST_NO_ACK;
		end else begin
			s = ST_BAD_ACK;
		end
		return s;
	endfunction

endpackage

### hw/rtl/swdh_cfg.sv
// ----------------------------------------------------------------------------
// swdh_cfg
// APB register file: turnaround length, error data phase, idle bit count
// ----------------------------------------------------------------------------
module swdh_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [swdh_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output swdh_pkg::cfg_t              cfg
);
	import swdh_pkg::*;

	logic [2:0] turn_q;
	logic       dphase_q;
	logic [7:0] idle_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_q   <= 3'd1;
			dphase_q <= 1'b0;
			idle_q   <= 8'd0;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_TURN:   turn_q   <= pwdata[2:0];
				REG_DPHASE: dphase_q <= pwdata[0];
				REG_IDLE:   idle_q   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_TURN:   prdata = {29'd0, turn_q};
			REG_DPHASE: prdata = {31'd0, dphase_q};
			REG_IDLE:   prdata = {24'd0, idle_q};
			default:    prdata = 32'd0;
		endcase
	end

	assign cfg.turnaround_cycles   = turn_q;
	assign cfg.data_phase_on_error = dphase_q;
	assign cfg.idle_len            = idle_q;

endmodule

### hw/rtl/swdh_core.sv
// ----------------------------------------------------------------------------
// swdh_core
// Transfer sequencer: one item per step, header, turnaround, ack, data, idle
// ----------------------------------------------------------------------------
module swdh_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  swdh_pkg::item_t   item,
	input  swdh_pkg::cfg_t    cfg,
	output swdh_pkg::result_t res
);
	import swdh_pkg::*;

	phase_t             phase_q, nx_phase;
	logic [CNT_W-1:0]   cnt_q, nx_cnt;
	logic [WORD_W-1:0]  shift_q, nx_shift;
	logic [3:0]         req_q, nx_req;
	logic [WORD_W-1:0]  wword_q, nx_wword;
	logic [2:0]         ack_q, nx_ack;
	logic               par_q, nx_par;
	logic [ATT_W-1:0]   att_q, nx_att;

	logic [CNT_W-1:0]   c_inc;
	logic [CNT_W-1:0]   tl;
	logic               rd;
	logic               bit_in;
	logic [2:0]         ack_new;
	logic               v;
	logic               do_fin;
	logic               do_tail;
	status_t            fin_st;
	logic [WORD_W-1:0]  fin_data;
	logic [7:0]         hdr;

	assign c_inc  = cnt_q + CNT_W'(1);
	assign tl     = CNT_W'(turn_len(cfg.turnaround_cycles));
	assign rd     = req_q[REQ_RNW_BIT];
	assign bit_in = item.line_in;
	assign hdr    = header_bits(req_q);

	always_comb begin
		nx_phase = phase_q;
		nx_cnt   = cnt_q;
		nx_shift = shift_q;
		nx_req   = req_q;
		nx_wword = wword_q;
		nx_ack   = ack_q;
		nx_par   = par_q;
		nx_att   = att_q;
		res      = '0;
		do_fin   = 1'b0;
		do_tail  = 1'b0;
		fin_st   = ST_OK;
		fin_data = '0;
		ack_new  = ack_q;
		v        = 1'b0;

		if (!item.cmd) begin
			if (phase_q == PH_IDLE) begin
				nx_req   = item.request;
				nx_wword = item.write_data;
				nx_phase = PH_HDR;
				nx_cnt   = '0;
				nx_shift = '0;
				nx_ack   = '0;
				nx_par   = 1'b0;
				nx_att   = '0;
			end
			res.busy_res = 1'b1;
		end else if (phase_q != PH_IDLE) begin
			res.clock_pulse = 1'b1;
			res.busy_res    = 1'b1;
			unique case (phase_q)
				PH_HDR: begin
					res.line_drive = 1'b1;
					res.line_out   = hdr[cnt_q[2:0]];
					if (cnt_q >= CNT_W'(7)) begin
						nx_phase = PH_TURN_A;
						nx_cnt   = '0;
					end else begin
						nx_cnt = c_inc;
					end
				end
				PH_TURN_A: begin
					if (c_inc >= tl) begin
						nx_phase = PH_ACK;
						nx_cnt   = '0;
						nx_ack   = '0;
					end else begin
						nx_cnt = c_inc;
					end
				end
				PH_ACK: begin
					unique case (cnt_q[1:0])
						2'd0:    ack_new = ack_q | {2'b00, bit_in};
						2'd1:    ack_new = ack_q | {1'b0, bit_in, 1'b0};
						2'd2:    ack_new = ack_q | {bit_in, 2'b00};
						default: ack_new = ack_q;
					endcase
					nx_ack = ack_new;
					if (cnt_q >= CNT_W'(2)) begin
						nx_cnt   = '0;
						nx_par   = 1'b0;
						nx_shift = '0;
						if (rd && (ack_new == ACK_OK || cfg.data_phase_on_error)) begin
							nx_phase = PH_RD;
						end else begin
							nx_phase = PH_TURN_B;
						end
					end else begin
						nx_cnt = c_inc;
					end
				end
				PH_RD: begin
					if (cnt_q < CNT_W'(WORD_W)) begin
						nx_shift = {bit_in, shift_q[WORD_W-1:1]};
					end
					nx_par = par_q ^ bit_in;
					if (cnt_q >= CNT_W'(WORD_W)) begin
						nx_phase = PH_TURN_B;
						nx_cnt   = '0;
					end else begin
						nx_cnt = c_inc;
					end
				end
				PH_TURN_B: begin
					if (c_inc < tl) begin
						nx_cnt = c_inc;
					end else begin
						nx_cnt = '0;
						if (ack_q == ACK_OK) begin
							if (rd) begin
								if (par_q) begin
									if ({1'b0, att_q} + (ATT_W+1)'(1) <
										(ATT_W+1)'(MAX_ATTEMPTS)) begin
										nx_att   = att_q + ATT_W'(1);
										nx_phase = PH_HDR;
									end else begin
										do_fin   = 1'b1;
										fin_st   = ST_PARITY;
										fin_data = shift_q;
									end
								end else begin
									do_tail = 1'b1;
								end
							end else begin
								nx_par   = 1'b0;
								nx_phase = PH_WR;
							end
						end else if (cfg.data_phase_on_error && !rd) begin
							nx_par   = 1'b0;
							nx_phase = PH_WR;
						end else begin
							do_fin = 1'b1;
							fin_st = error_status(ack_q);
						end
					end
				end
				PH_WR: begin
					res.line_drive = 1'b1;
					if (cnt_q < CNT_W'(WORD_W)) begin
						v      = (ack_q == ACK_OK) ? wword_q[cnt_q[4:0]] : 1'b0;
						nx_par = par_q ^ v;
					end else begin
						v = par_q;
					end
					res.line_out = v;
					if (cnt_q >= CNT_W'(WORD_W)) begin
						nx_cnt = '0;
						if (ack_q == ACK_OK) begin
							do_tail = 1'b1;
						end else begin
							do_fin = 1'b1;
							fin_st = error_status(ack_q);
						end
					end else begin
						nx_cnt = c_inc;
					end
				end
				PH_IDLE_BITS: begin
					res.line_drive = 1'b1;
					if (c_inc >= cfg.idle_len) begin
						do_fin   = 1'b1;
						fin_data = rd ? shift_q : '0;
					end else begin
						nx_cnt = c_inc;
					end
				end
				PH_IDLE: ;
			endcase

			if (do_tail) begin
				if (cfg.idle_len != 8'd0) begin
					nx_phase = PH_IDLE_BITS;
					nx_cnt   = '0;
				end else begin
					do_fin   = 1'b1;
					fin_st   = ST_OK;
					fin_data = rd ? shift_q : '0;
				end
			end
			if (do_fin) begin
				nx_phase      = PH_IDLE;
				nx_cnt        = '0;
				res.busy_res  = 1'b0;
				res.done_res  = 1'b1;
				res.status    = fin_st;
				res.read_data = fin_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			shift_q <= '0;
			req_q   <= '0;
			wword_q <= '0;
			ack_q   <= '0;
			par_q   <= 1'b0;
			att_q   <= '0;
		end else if (step) begin
			phase_q <= nx_phase;
			cnt_q   <= nx_cnt;
			shift_q <= nx_shift;
			req_q   <= nx_req;
			wword_q <= nx_wword;
			ack_q   <= nx_ack;
			par_q   <= nx_par;
			att_q   <= nx_att;
		end
	end

	a_idle_cnt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> cnt_q == '0)
		else $error("counter left running in idle");

	a_hdr_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HDR |-> cnt_q <= CNT_W'(7))
		else $error("header counter out of range");

	a_status_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		step && !res.done_res |-> res.status == ST_OK && res.read_data == '0)
		else $error("status or data reported without done");

	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.done_res |=> phase_q == PH_IDLE)
		else $error("engine still busy after done");

endmodule

### hw/rtl/swd_host_transfer_engine_unit.sv
// ----------------------------------------------------------------------------
// swd_host_transfer_engine_unit
// SWD host transfer engine: stream items in, one result per item out
// ----------------------------------------------------------------------------
// latency: the input register and then the result register lie between an input transaction and its result on m_tvalid
// throughput: one item per cycle unless m_tready stalls the result side, set by the single sequencer step per item
// an input register and a result register part the two stream sides
// reset clears all control state, the sequencer goes idle
// registers reset to turnaround 1, no error data phase, no idle bits
module swd_host_transfer_engine_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// request[3:0], write_data[35:4], line_in[36], zero[39:37]
	input  logic [swdh_pkg::TDATA_IN_W-1:0]  s_tdata,
	// cmd[0]
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// line_out[0], line_drive[1], clock_pulse[2], busy_res[3], done_res[4],
	// status[7:5], read_data[39:8]
	output logic [swdh_pkg::TDATA_OUT_W-1:0] m_tdata,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [swdh_pkg::ADDR_W-1:0]      paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	import swdh_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t res_s2;
	logic    step;
	result_t res;
	cfg_t    cfg;

	assign step     = valid_s1 & (~valid_s2 | m_tready);
	assign s_tready = ~valid_s1 | step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.cmd        <= s_tuser;
			item_s1.request    <= s_tdata[3:0];
			item_s1.write_data <= s_tdata[35:4];
			item_s1.line_in    <= s_tdata[36];
		end
	end

	swdh_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	swdh_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (step) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = res_s2;

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !step |=> valid_s1)
		else $error("input register dropped an item");

	a_step_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> !valid_s2 || m_tready)
		else $error("result register overwritten");

	a_s2_fill: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> valid_s2)
		else $error("result lost after step");

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Runs SWD transfers through the host transfer engine one bit tick at a time.
// The acknowledge levels come from a plan per transfer, read data bits are
// random, and every result transaction is compared field by field with the engine model.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import swdh_pkg::*;

	localparam logic        CMD_START   = 1'b0;
	localparam logic        CMD_TICK    = 1'b1;
	localparam int unsigned ITEM_TARGET = 1250;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [TDATA_IN_W-1:0]  s_tdata  = '0;
	logic                   s_tuser  = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_tdata;
	logic                   psel     = 1'b0;
	logic                   penable  = 1'b0;
	logic                   pwrite   = 1'b0;
	logic [ADDR_W-1:0]      paddr    = '0;
	logic [31:0]            pwdata   = '0;
	logic [31:0]            prdata;
	logic                   pready;

	// engine model state and its copy of the registers
	logic [2:0]  cfg_turn   = 3'd1;
	logic        cfg_dphase = 1'b0;
	logic [7:0]  cfg_idle   = 8'd0;
	phase_t      eng_phase  = PH_IDLE;
	logic [7:0]  eng_cnt    = '0;
	logic [31:0] eng_shift  = '0;
	logic [3:0]  eng_req    = '0;
	logic [31:0] eng_wword  = '0;
	logic [2:0]  eng_ack    = '0;
	logic        eng_par    = 1'b0;
	logic [2:0]  eng_tries  = '0;

	result_t     pending_results[$];
	int unsigned sent_items  = 0;
	int          bad_results = 0;
	bit          tx_calm     = 1'b0;
	bit          rx_calm     = 1'b0;
	int unsigned rx_hold     = 0;

	always #4 clk = ~clk;

	swd_host_transfer_engine_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	function automatic status_t ack_to_status(input logic [2:0] ack);
		case (ack)
			ACK_WAIT:  return ST_WAIT;
			ACK_FAULT: return ST_FAULT;
			ACK_NONE:  return ST_NO_ACK;
			default:   return ST_BAD_ACK;
		endcase
	endfunction

	function automatic void end_transfer(inout result_t r, input status_t st,
		input logic [31:0] word);
		eng_phase   = PH_IDLE;
		eng_cnt     = '0;
		r.busy_res  = 1'b0;
		r.done_res  = 1'b1;
		r.status    = st;
		r.read_data = word;
	endfunction

	function automatic void close_ok(inout result_t r);
		if (cfg_idle != 8'd0) begin
			eng_phase = PH_IDLE_BITS;
			eng_cnt   = '0;
		end else begin
			end_transfer(r, ST_OK, eng_req[REQ_RNW_BIT] ? eng_shift : 32'd0);
		end
	endfunction

	function automatic result_t swd_bit_step(input logic cmd, input logic [3:0] req,
		input logic [31:0] wword, input logic line);
		result_t     r;
		int unsigned c;
		int unsigned tl;
		logic        rd;
		logic        v;
		r  = '0;
		c  = eng_cnt;
		tl = (cfg_turn == 3'd0) ? 1 : (cfg_turn > 3'd4) ? 4 : cfg_turn;
		rd = eng_req[REQ_RNW_BIT];
		if (cmd == CMD_START) begin
			if (eng_phase == PH_IDLE) begin
				eng_req   = req;
				eng_wword = wword;
				eng_phase = PH_HDR;
				eng_cnt   = '0;
				eng_shift = '0;
				eng_ack   = '0;
				eng_par   = 1'b0;
				eng_tries = '0;
			end
			r.busy_res = 1'b1;
			return r;
		end
		if (eng_phase == PH_IDLE) begin
			return r;
		end
		r.clock_pulse = 1'b1;
		r.busy_res    = 1'b1;
		case (eng_phase)
			PH_HDR: begin
				r.line_drive = 1'b1;
				case (c)
					0, 7:       r.line_out = 1'b1;
					1, 2, 3, 4: r.line_out = eng_req[c-1];
					5:          r.line_out = ^eng_req;
					default:    r.line_out = 1'b0;
				endcase
				if (c >= 7) begin
					eng_phase = PH_TURN_A;
					eng_cnt   = '0;
				end else begin
					eng_cnt = 8'(c + 1);
				end
			end
			PH_TURN_A: begin
				if (c + 1 >= tl) begin
					eng_phase = PH_ACK;
					eng_cnt   = '0;
					eng_ack   = '0;
				end else begin
					eng_cnt = 8'(c + 1);
				end
			end
			PH_ACK: begin
				eng_ack[c] = line;
				if (c >= 2) begin
					eng_cnt   = '0;
					eng_par   = 1'b0;
					eng_shift = '0;
					eng_phase = (rd && (eng_ack == ACK_OK || cfg_dphase)) ? PH_RD : PH_TURN_B;
				end else begin
					eng_cnt = 8'(c + 1);
				end
			end
			PH_RD: begin
				if (c < 32) begin
					eng_shift = {line, eng_shift[31:1]};
				end
				eng_par ^= line;
				if (c >= 32) begin
					eng_phase = PH_TURN_B;
					eng_cnt   = '0;
				end else begin
					eng_cnt = 8'(c + 1);
				end
			end
			PH_TURN_B: begin
				if (c + 1 < tl) begin
					eng_cnt = 8'(c + 1);
				end else begin
					eng_cnt = '0;
					if (eng_ack == ACK_OK) begin
						if (!rd) begin
							eng_par   = 1'b0;
							eng_phase = PH_WR;
						end else if (!eng_par) begin
							close_ok(r);
						end else if (eng_tries < MAX_ATTEMPTS - 1) begin
							eng_tries++;
							eng_phase = PH_HDR;
						end else begin
							end_transfer(r, ST_PARITY, eng_shift);
						end
					end else if (cfg_dphase && !rd) begin
						eng_par   = 1'b0;
						eng_phase = PH_WR;
					end else begin
						end_transfer(r, ack_to_status(eng_ack), 32'd0);
					end
				end
			end
			PH_WR: begin
				r.line_drive = 1'b1;
				if (c < 32) begin
					v = (eng_ack == ACK_OK) ? eng_wword[c] : 1'b0;
					eng_par ^= v;
				end else begin
					v = eng_par;
				end
				r.line_out = v;
				if (c >= 32) begin
					eng_cnt = '0;
					if (eng_ack == ACK_OK) begin
						close_ok(r);
					end else begin
						end_transfer(r, ack_to_status(eng_ack), 32'd0);
					end
				end else begin
					eng_cnt = 8'(c + 1);
				end
			end
			PH_IDLE_BITS: begin
				r.line_drive = 1'b1;
				if (c + 1 >= cfg_idle) begin
					end_transfer(r, ST_OK, rd ? eng_shift : 32'd0);
				end else begin
					eng_cnt = 8'(c + 1);
				end
			end
			default: begin
				eng_phase     = PH_IDLE;
				r.clock_pulse = 1'b0;
				r.busy_res    = 1'b0;
			end
		endcase
		return r;
	endfunction

	function automatic void check_field(input string what, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t %s expected %0h actual %0h", $time, what, want, got);
			bad_results++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : result_side
		result_t     got;
		result_t     want;
		int unsigned stall;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_hold  <= 0;
		end else if (m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_results.size() == 0) begin
				$display("%0t result with none expected: expected none actual %0h",
					$time, m_tdata);
				bad_results++;
			end else begin
				want = pending_results.pop_front();
				check_field("line_out", want.line_out, got.line_out);
				check_field("line_drive", want.line_drive, got.line_drive);
				check_field("clock_pulse", want.clock_pulse, got.clock_pulse);
				check_field("busy_res", want.busy_res, got.busy_res);
				check_field("done_res", want.done_res, got.done_res);
				check_field("status", want.status, got.status);
				check_field("read_data", want.read_data, got.read_data);
			end
			if ($urandom_range(0, 39) == 0) begin
				rx_calm = !rx_calm;
			end
			stall = rx_calm ? 0 : $urandom_range(0, 12);
			rx_hold  <= stall;
			m_tready <= (stall == 0);
		end else if (rx_hold != 0) begin
			rx_hold  <= rx_hold - 1;
			m_tready <= (rx_hold == 1);
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_item(input logic cmd, input logic [3:0] req, input logic [31:0] wword,
		input logic line);
		int unsigned gap;
		if ($urandom_range(0, 59) == 0) begin
			tx_calm = !tx_calm;
		end
		gap = tx_calm ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {3'b000, line, wword, req};
		do @(posedge clk); while (!s_tready);
		sent_items++;
		pending_results.push_back(swd_bit_step(cmd, req, wword, line));
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input logic [2:0] turn, input logic dphase, input logic [7:0] idle);
		logic [1:0]  regs [3];
		logic [31:0] values [3];
		int          i;
		regs   = '{REG_TURN, REG_DPHASE, REG_IDLE};
		values = '{{29'd0, turn}, {31'd0, dphase}, {24'd0, idle}};
		for (i = 0; i < 3; i++) begin
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= 1'b1;
			paddr   <= {regs[i], 2'b00};
			pwdata  <= values[i];
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		cfg_turn   = turn;
		cfg_dphase = dphase;
		cfg_idle   = idle;
	endtask

	// target line levels: ack bits from the plan, parity bit spoilt while faults remain
	task automatic run_ticks(input logic [2:0] ack_plan, inout int unsigned parity_faults,
		input phase_t stop_at);
		logic line;
		while (eng_phase != PH_IDLE && eng_phase != stop_at) begin
			if ($urandom_range(0, 29) == 0) begin
				send_item(CMD_START, 4'($urandom), $urandom, 1'($urandom));
			end else begin
				line = 1'($urandom);
				if (eng_phase == PH_ACK) begin
					line = ack_plan[eng_cnt[1:0]];
				end else if (eng_phase == PH_RD && eng_cnt == 8'd32 && eng_ack == ACK_OK) begin
					line = eng_par ^ (parity_faults != 0);
					if (parity_faults != 0) begin
						parity_faults--;
					end
				end
				send_item(CMD_TICK, 4'($urandom), $urandom, line);
			end
		end
	endtask

	task automatic run_transfer(input logic [3:0] req, input logic [31:0] wword,
		input logic [2:0] ack_plan, input int unsigned parity_faults);
		send_item(CMD_START, req, wword, 1'($urandom));
		run_ticks(ack_plan, parity_faults, PH_IDLE);
	endtask

	task automatic test_idle_ticks();
		repeat (3) send_item(CMD_TICK, 4'($urandom), $urandom, 1'($urandom));
	endtask

	task automatic test_plain_transfers();
		run_transfer(4'h0, 32'hFFFF_FFFF, ACK_OK, 0);
		run_transfer(4'hD, 32'h0000_0000, ACK_OK, 0);
		run_transfer(4'hF, $urandom, ACK_OK, 1);
		run_transfer(4'h2, $urandom, ACK_OK, 0);
	endtask

	task automatic test_error_acks();
		settle();
		configure(3'd7, 1'b1, 8'd40);
		run_transfer(4'h2, $urandom, ACK_WAIT, 0);
		run_transfer(4'h9, $urandom, ACK_FAULT, 0);
		run_transfer(4'hB, $urandom, ACK_NONE, 0);
		run_transfer(4'h4, $urandom, 3'b000, 0);
		run_transfer(4'h1, $urandom, ACK_OK, 0);
	endtask

	task automatic test_parity_exhaustion();
		settle();
		configure(3'd0, 1'b0, 8'd0);
		run_transfer(4'hE, $urandom, ACK_OK, MAX_ATTEMPTS);
		run_transfer(4'h6, $urandom, ACK_WAIT, 0);
		run_transfer(4'h8, $urandom, 3'b110, 0);
		run_transfer(4'h5, $urandom, ACK_FAULT, 0);
	endtask

	task automatic test_config_mid_transfer();
		int unsigned faults;
		faults = 0;
		settle();
		configure(3'd4, 1'b0, 8'd1);
		send_item(CMD_START, 4'h1, $urandom, 1'b0);
		run_ticks(ACK_OK, faults, PH_WR);
		settle();
		configure(3'd2, 1'b1, 8'd6);
		run_ticks(ACK_OK, faults, PH_IDLE);
		faults = 1;
		send_item(CMD_START, 4'h3, $urandom, 1'b1);
		run_ticks(ACK_OK, faults, PH_RD);
		settle();
		configure(3'd5, 1'b0, 8'd0);
		run_ticks(ACK_OK, faults, PH_IDLE);
	endtask

	task automatic test_random_transfers();
		int unsigned pick;
		int unsigned faults;
		logic [7:0]  idle;
		logic [2:0]  ack;
		do begin
			if ($urandom_range(0, 5) == 0) begin
				pick = $urandom_range(0, 19);
				idle = (pick == 0) ? 8'($urandom_range(200, 255)) :
					(pick < 6) ? 8'($urandom_range(4, 20)) : 8'($urandom_range(0, 3));
				settle();
				configure(3'($urandom), 1'($urandom), idle);
			end
			if ($urandom_range(0, 7) == 0) begin
				repeat ($urandom_range(1, 2)) send_item(CMD_TICK, 4'($urandom), $urandom,
					1'($urandom));
			end
			pick   = $urandom_range(0, 19);
			faults = (pick == 0) ? MAX_ATTEMPTS : (pick < 5) ? pick : 0;
			ack    = ($urandom_range(0, 99) < 60) ? ACK_OK : 3'($urandom);
			run_transfer(4'($urandom), $urandom, ack, faults);
		end while (sent_items < ITEM_TARGET);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_idle_ticks();
		test_plain_transfers();
		test_error_acks();
		test_parity_exhaustion();
		test_config_mid_transfer();
		test_random_transfers();
		settle();
		if (bad_results == 0) begin
			$display("swd_host_transfer_engine_unit: match");
		end else begin
			$display("swd_host_transfer_engine_unit: mismatch");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("swd_host_transfer_engine_unit: mismatch");
		$finish;
	end

endmodule
